### rtl/fsbm_pkg.sv
// Package for the full search block matcher: FSM states, status codes,
// register indexes and the command/status bundles between control and datapath.
// No dependencies.
package fsbm_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_CHECK,
		ST_ACCUM,
		ST_DRAIN,
		ST_NEXT,
		ST_RESULT
	} state_t;

	localparam logic [1:0] STATUS_MATCH = 2'd0;
	localparam logic [1:0] STATUS_EDGE  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	localparam logic CMD_LOAD     = 1'b0;
	localparam logic CMD_ESTIMATE = 1'b1;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_HBLOCK = 2'd2;
	localparam logic [1:0] REG_HWIN   = 2'd3;

	localparam int CHANNELS = 3;

	// commands from controller to datapath
	typedef struct packed {
		logic setup;      // latch position, compute bounds
		logic cand_start; // reset pixel walk for the current candidate
		logic issue;      // read one pixel pair and advance the walk
		logic compare;    // compare finished sum against best
		logic next_cand;  // step to next candidate in raster order
	} dp_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic edge_hit;   // pixel too near edge
		logic win_empty;  // no candidate
		logic walk_last;  // issuing the last pixel of the block
		logic cand_last;  // current candidate is the last
		logic pipe_busy;  // pixel pipeline still holds reads
	} dp_stat_t;

endpackage

### rtl/full_search_block_match_sad.sv
// Top level of the full search SAD block matcher: APB registers, channel
// handshakes and output register. Depends on fsbm_pkg, fsbm_ctrl, fsbm_datapath.
//
// channel   | handshake           | payload
// ----------+---------------------+------------------------------------------
// input     | in_valid/in_ready   | command, pos_x, pos_y, cur_*, ref_*
// output    | out_valid/out_ready | status, best_sad, best_x, best_y
// config    | APB psel/penable    | paddr, pwdata, prdata
//
// A load is written straight into both frame memories. During an estimate one
// pixel pair is read from the frame memories per cycle while a candidate's block
// is walked; edge and empty cases finish without reading any pixel.
// Reset idles control, sets register defaults; frame contents are undefined.
// A waiting result holds the output register and the input until it is taken.
module full_search_block_match_sad #(
	parameter int MAX_WIDTH       = 64,
	parameter int MAX_HEIGHT      = 64,
	parameter int MAX_HALF_BLOCK  = 3,
	parameter int MAX_HALF_WINDOW = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [5:0]  pos_x,
	input  logic [5:0]  pos_y,
	input  logic [7:0]  cur_red,
	input  logic [7:0]  cur_green,
	input  logic [7:0]  cur_blue,
	input  logic [7:0]  ref_red,
	input  logic [7:0]  ref_green,
	input  logic [7:0]  ref_blue,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [15:0] best_sad,
	output logic [5:0]  best_x,
	output logic [5:0]  best_y,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [6:0] width_q, height_q;
	logic [1:0] hblock_q;
	logic [3:0] hwin_q;
	logic [1:0] reg_idx;

	assign pready = 1'b1;
	assign reg_idx = paddr[3:2];

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 7'd64;
			height_q <= 7'd64;
			hblock_q <= 2'd1;
			hwin_q <= 4'd5;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				fsbm_pkg::REG_WIDTH:  width_q <= pwdata[6:0];
				fsbm_pkg::REG_HEIGHT: height_q <= pwdata[6:0];
				fsbm_pkg::REG_HBLOCK: hblock_q <= pwdata[1:0];
				fsbm_pkg::REG_HWIN:   hwin_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			fsbm_pkg::REG_WIDTH:  prdata = 32'(width_q);
			fsbm_pkg::REG_HEIGHT: prdata = 32'(height_q);
			fsbm_pkg::REG_HBLOCK: prdata = 32'(hblock_q);
			fsbm_pkg::REG_HWIN:   prdata = 32'(hwin_q);
			default: ;
		endcase
	end

	fsbm_pkg::dp_cmd_t  cmd;
	fsbm_pkg::dp_stat_t stat;
	logic busy, done, in_acc, start;
	logic [1:0] done_status;
	logic [15:0] res_sad;
	logic [5:0] res_x, res_y;

	// a finished result must find the output register free
	assign in_ready = !busy && (!out_valid || out_ready);
	assign in_acc = in_valid && in_ready;
	assign start = in_acc && (command == fsbm_pkg::CMD_ESTIMATE);

	fsbm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .stat(stat), .cmd(cmd),
		.busy(busy), .done(done), .done_status(done_status)
	);

	fsbm_datapath #(
		.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
		.MAX_HALF_BLOCK(MAX_HALF_BLOCK), .MAX_HALF_WINDOW(MAX_HALF_WINDOW),
		.XW(6), .YW(6), .WREG(7), .HREG(7), .SADW(16)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.load_en(in_acc && command == fsbm_pkg::CMD_LOAD),
		.in_x(pos_x), .in_y(pos_y),
		.cur_pix({cur_blue, cur_green, cur_red}),
		.ref_pix({ref_blue, ref_green, ref_red}),
		.cfg_w(width_q), .cfg_h(height_q), .cfg_hb(hblock_q), .cfg_hw(hwin_q),
		.res_sad(res_sad), .res_x(res_x), .res_y(res_y)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (done) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			status <= done_status;
			best_sad <= (done_status == fsbm_pkg::STATUS_MATCH) ? res_sad : '0;
			best_x <= (done_status == fsbm_pkg::STATUS_MATCH) ? res_x : '0;
			best_y <= (done_status == fsbm_pkg::STATUS_MATCH) ? res_y : '0;
		end
	end

endmodule

### rtl/fsbm_datapath.sv
// Datapath: frame memories, bounds, pixel walk, SAD accumulation, best tracking.
// Depends on fsbm_pkg.
module fsbm_datapath #(
	parameter int MAX_WIDTH       = 64,
	parameter int MAX_HEIGHT      = 64,
	parameter int MAX_HALF_BLOCK  = 3,
	parameter int MAX_HALF_WINDOW = 8,
	parameter int XW = 6,
	parameter int YW = 6,
	parameter int WREG = 7,
	parameter int HREG = 7,
	parameter int SADW = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  fsbm_pkg::dp_cmd_t   cmd,
	output fsbm_pkg::dp_stat_t  stat,
	input  logic                load_en,
	input  logic [XW-1:0]       in_x,
	input  logic [YW-1:0]       in_y,
	input  logic [23:0]         cur_pix,
	input  logic [23:0]         ref_pix,
	input  logic [WREG-1:0]     cfg_w,
	input  logic [HREG-1:0]     cfg_h,
	input  logic [1:0]          cfg_hb,
	input  logic [3:0]          cfg_hw,
	output logic [SADW-1:0]     res_sad,
	output logic [XW-1:0]       res_x,
	output logic [YW-1:0]       res_y
);

	localparam int AW = $clog2(MAX_WIDTH*MAX_HEIGHT);
	localparam int CW = 12; // signed coordinate width, ample for 1024 plus margins
	// full block sum width, so that comparisons never wrap
	localparam int SUMW = $clog2((2*MAX_HALF_BLOCK+1)*(2*MAX_HALF_BLOCK+1)*255*
		fsbm_pkg::CHANNELS + 1);

	logic [23:0] cur_mem [MAX_WIDTH*MAX_HEIGHT];
	logic [23:0] ref_mem [MAX_WIDTH*MAX_HEIGHT];

	logic signed [CW-1:0] w_c, h_c, hb_c, hw_c;
	logic signed [CW-1:0] x_q, y_q, hb_q;
	logic signed [CW-1:0] xmin_q, xmax_q, ymin_q, ymax_q, sx_q, sy_q;
	logic signed [CW-1:0] dx_q, dy_q;
	logic edge_q, empty_q;
	logic [SUMW-1:0] sum_q, best_q;
	logic [CW-1:0] bx_q, by_q;
	logic v_s1, v_s2;
	logic [23:0] ca_s1, cb_s1;
	logic [9:0] d_s2;
	logic load_ok;

	// row-major pixel address
	function automatic logic [AW-1:0] pix_addr(input logic [YW-1:0] py,
			input logic [XW-1:0] px);
		return AW'(py) * AW'(MAX_WIDTH) + AW'(px);
	endfunction

	// clamp the register values
	always_comb begin
		w_c = (cfg_w == '0) ? CW'(1) : ((32'(cfg_w) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(cfg_w));
		h_c = (cfg_h == '0) ? CW'(1) :
			((32'(cfg_h) > MAX_HEIGHT) ? CW'(MAX_HEIGHT) : CW'(cfg_h));
		hb_c = (32'(cfg_hb) > MAX_HALF_BLOCK) ? CW'(MAX_HALF_BLOCK) : CW'(cfg_hb);
		hw_c = (32'(cfg_hw) > MAX_HALF_WINDOW) ? CW'(MAX_HALF_WINDOW) : CW'(cfg_hw);
	end

	// drop loads that fall outside the storage
	assign load_ok = load_en && (32'(in_x) < MAX_WIDTH) && (32'(in_y) < MAX_HEIGHT);

	// load both frames
	always_ff @(posedge clk) begin
		if (load_ok) begin
			cur_mem[pix_addr(in_y, in_x)] <= cur_pix;
			ref_mem[pix_addr(in_y, in_x)] <= ref_pix;
		end
	end

	// latch position and window bounds
	always_ff @(posedge clk) begin
		logic signed [CW-1:0] xs, ys, a, b, c, d;
		if (cmd.setup) begin
			xs = CW'(in_x);
			ys = CW'(in_y);
			a = xs - hw_c + hb_c;
			b = xs + hw_c - hb_c;
			c = ys - hw_c + hb_c;
			d = ys + hw_c - hb_c;
			if (a < hb_c) a = hb_c;
			if (b > w_c - hb_c - 1) b = w_c - hb_c - 1;
			if (c < hb_c) c = hb_c;
			if (d > h_c - hb_c - 1) d = h_c - hb_c - 1;
			x_q <= xs;
			y_q <= ys;
			hb_q <= hb_c;
			edge_q <= (xs >= w_c) || (ys >= h_c) || (xs < hb_c) || (ys < hb_c) ||
				(xs >= w_c - hb_c) || (ys >= h_c - hb_c);
			empty_q <= (a > b) || (c > d);
			xmin_q <= a;
			xmax_q <= b;
			ymin_q <= c;
			ymax_q <= d;
			sx_q <= a;
			sy_q <= c;
		end else if (cmd.next_cand) begin
			if (sx_q == xmax_q) begin
				sx_q <= xmin_q;
				sy_q <= sy_q + 1'b1;
			end else begin
				sx_q <= sx_q + 1'b1;
			end
		end
	end

	// walk the block offsets
	always_ff @(posedge clk) begin
		if (cmd.cand_start) begin
			dx_q <= -hb_q;
			dy_q <= -hb_q;
		end else if (cmd.issue) begin
			if (dx_q == hb_q) begin
				dx_q <= -hb_q;
				dy_q <= dy_q + 1'b1;
			end else begin
				dx_q <= dx_q + 1'b1;
			end
		end
	end

	// read one pixel pair per cycle while issue is asserted
	logic [CW-1:0] ax, ay, bxx, byy;
	assign ax  = x_q + dx_q;
	assign ay  = y_q + dy_q;
	assign bxx = sx_q + dx_q;
	assign byy = sy_q + dy_q;

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			ca_s1 <= cur_mem[pix_addr(ay[YW-1:0], ax[XW-1:0])];
			cb_s1 <= ref_mem[pix_addr(byy[YW-1:0], bxx[XW-1:0])];
		end
	end

	// absolute differences over colours
	always_ff @(posedge clk) begin
		logic [9:0] s;
		logic [7:0] p, q;
		s = '0;
		for (int k = 0; k < fsbm_pkg::CHANNELS; k++) begin
			p = ca_s1[8*k +: 8];
			q = cb_s1[8*k +: 8];
			s = s + 10'((p > q) ? (p - q) : (q - p));
		end
		d_s2 <= s;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
		end
	end

	// accumulate and keep the best
	always_ff @(posedge clk) begin
		if (cmd.cand_start) begin
			sum_q <= '0;
		end else if (v_s2) begin
			sum_q <= sum_q + SUMW'(d_s2);
		end
		if (cmd.setup) begin
			best_q <= '1;
			bx_q <= '0;
			by_q <= '0;
		end else if (cmd.compare) begin
			if (sum_q < best_q || (bx_q == '0 && by_q == '0 && best_q == '1 &&
					sx_q == xmin_q && sy_q == ymin_q)) begin
				best_q <= sum_q;
				bx_q <= sx_q;
				by_q <= sy_q;
			end
		end
	end

	assign stat.edge_hit  = edge_q;
	assign stat.win_empty = empty_q;
	assign stat.walk_last = (dx_q == hb_q) && (dy_q == hb_q);
	assign stat.cand_last = (sx_q == xmax_q) && (sy_q == ymax_q);
	assign stat.pipe_busy = v_s1 || v_s2;

	assign res_sad = SADW'(best_q);
	assign res_x   = bx_q[XW-1:0];
	assign res_y   = by_q[YW-1:0];

endmodule

### rtl/fsbm_ctrl.sv
// Controller state machine sequencing candidates and pixel walks.
// Depends on fsbm_pkg.
module fsbm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  fsbm_pkg::dp_stat_t  stat,
	output fsbm_pkg::dp_cmd_t   cmd,
	output logic                busy,
	output logic                done,
	output logic [1:0]          done_status
);

	fsbm_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fsbm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fsbm_pkg::ST_IDLE:   if (start) state_d = fsbm_pkg::ST_SETUP;
			fsbm_pkg::ST_SETUP:  state_d = fsbm_pkg::ST_CHECK;
			fsbm_pkg::ST_CHECK: begin
				if (stat.edge_hit || stat.win_empty) state_d = fsbm_pkg::ST_RESULT;
				else state_d = fsbm_pkg::ST_ACCUM;
			end
			fsbm_pkg::ST_ACCUM:  if (stat.walk_last) state_d = fsbm_pkg::ST_DRAIN;
			fsbm_pkg::ST_DRAIN:  if (!stat.pipe_busy) state_d = fsbm_pkg::ST_NEXT;
			fsbm_pkg::ST_NEXT: begin
				if (stat.cand_last) state_d = fsbm_pkg::ST_RESULT;
				else state_d = fsbm_pkg::ST_ACCUM;
			end
			fsbm_pkg::ST_RESULT: state_d = fsbm_pkg::ST_IDLE;
			default:             state_d = fsbm_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		busy = 1'b1;
		done = 1'b0;
		done_status = fsbm_pkg::STATUS_MATCH;
		unique case (state_q)
			fsbm_pkg::ST_IDLE: begin
				busy = 1'b0;
				cmd.setup = start;
			end
			fsbm_pkg::ST_SETUP: ;
			fsbm_pkg::ST_CHECK:  cmd.cand_start = 1'b1;
			fsbm_pkg::ST_ACCUM:  cmd.issue = 1'b1;
			fsbm_pkg::ST_DRAIN:  cmd.compare = !stat.pipe_busy;
			fsbm_pkg::ST_NEXT: begin
				cmd.next_cand = !stat.cand_last;
				cmd.cand_start = 1'b1;
			end
			fsbm_pkg::ST_RESULT: begin
				done = 1'b1;
				if (stat.edge_hit) done_status = fsbm_pkg::STATUS_EDGE;
				else if (stat.win_empty) done_status = fsbm_pkg::STATUS_EMPTY;
			end
			default: ;
		endcase
	end

endmodule

### tb/tb_full_search_block_match_sad.sv
// Self-checking testbench for full_search_block_match_sad: loads frame pixels, asks for
// motion estimates and checks every result against an in-bench SAD search predictor.
// Depends on fsbm_pkg and the RTL of the block under test.
module tb_full_search_block_match_sad;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAME_DIM   = 64;
	localparam int HB_MAX      = 3;
	localparam int HW_MAX      = 8;
	localparam int STALL_LIMIT = 60000;
	localparam int HOLD_CYCLES = 2500;

	typedef struct packed {
		logic       command;
		logic [5:0] x;
		logic [5:0] y;
		logic [7:0] cr, cg, cb;
		logic [7:0] rr, rg, rb;
	} pixel_item_t;

	typedef struct {
		logic [1:0]  status;
		logic [15:0] sad;
		logic [5:0]  bx;
		logic [5:0]  by;
	} match_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] status;
	logic [15:0] best_sad;
	logic [5:0] best_x, best_y;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	pixel_item_t drv = '0;

	// predictor state: frames and raw register values
	logic [23:0] cur_frame [FRAME_DIM*FRAME_DIM];
	logic [23:0] ref_frame [FRAME_DIM*FRAME_DIM];
	bit          loaded [FRAME_DIM*FRAME_DIM];
	int cfg_w = 64, cfg_h = 64, cfg_hb = 1, cfg_hw = 5;

	pixel_item_t pending_items[$];
	match_t      expected_matches[$];
	int send_idle = 0, recv_idle = 0;
	int mismatches = 0;
	int results_seen = 0;
	int hold_left = 0;
	bit hold_done = 0;
	int quiet_cycles = 0;
	int items_queued = 0;

	full_search_block_match_sad i_dut (
		.clk, .arst_n, .in_valid, .in_ready,
		.command(drv.command), .pos_x(drv.x), .pos_y(drv.y),
		.cur_red(drv.cr), .cur_green(drv.cg), .cur_blue(drv.cb),
		.ref_red(drv.rr), .ref_green(drv.rg), .ref_blue(drv.rb),
		.out_valid, .out_ready, .status, .best_sad, .best_x, .best_y,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	always #5 clk = ~clk;

	function automatic int clampi(input int v, input int lo, input int hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// work out the clamped search window, or the edge / empty status
	function automatic logic [1:0] search_window(input int x, input int y, output int hb,
			output int x0, output int x1, output int y0, output int y1);
		int w, h, hw;
		w  = clampi(cfg_w, 1, FRAME_DIM);
		h  = clampi(cfg_h, 1, FRAME_DIM);
		hb = clampi(cfg_hb, 0, HB_MAX);
		hw = clampi(cfg_hw, 0, HW_MAX);
		x0 = 0; x1 = -1; y0 = 0; y1 = -1;
		if (x >= w || y >= h || x < hb || y < hb || x >= w - hb || y >= h - hb)
			return fsbm_pkg::STATUS_EDGE;
		x0 = (x - hw + hb < hb) ? hb : x - hw + hb;
		x1 = (x + hw - hb > w - hb - 1) ? w - hb - 1 : x + hw - hb;
		y0 = (y - hw + hb < hb) ? hb : y - hw + hb;
		y1 = (y + hw - hb > h - hb - 1) ? h - hb - 1 : y + hw - hb;
		if (x0 > x1 || y0 > y1) return fsbm_pkg::STATUS_EMPTY;
		return fsbm_pkg::STATUS_MATCH;
	endfunction

	function automatic int pixel_cost(input logic [23:0] a, input logic [23:0] b);
		int sum, ca, cb;
		sum = 0;
		for (int k = 0; k < 3; k++) begin
			ca = a[8*k +: 8];
			cb = b[8*k +: 8];
			sum += (ca > cb) ? ca - cb : cb - ca;
		end
		return sum;
	endfunction

	// full search: least SAD, first in raster order on a tie
	function automatic match_t best_match(input int x, input int y);
		match_t m;
		int hb, x0, x1, y0, y1, sum, least;
		m = '{status: fsbm_pkg::STATUS_MATCH, sad: '0, bx: '0, by: '0};
		m.status = search_window(x, y, hb, x0, x1, y0, y1);
		if (m.status != fsbm_pkg::STATUS_MATCH) return m;
		least = -1;
		for (int sy = y0; sy <= y1; sy++) begin
			for (int sx = x0; sx <= x1; sx++) begin
				sum = 0;
				for (int dy = -hb; dy <= hb; dy++)
					for (int dx = -hb; dx <= hb; dx++)
						sum += pixel_cost(cur_frame[(y+dy)*FRAME_DIM + x+dx],
							ref_frame[(sy+dy)*FRAME_DIM + sx+dx]);
				if (least < 0 || sum < least) begin
					least = sum;
					m.bx = sx[5:0];
					m.by = sy[5:0];
				end
			end
		end
		m.sad = least[15:0];
		return m;
	endfunction

	// colours drawn partly from a coarse palette so that ties occur
	function automatic logic [7:0] pick_colour();
		if ($urandom_range(1)) return 8'($urandom_range(255));
		return 8'($urandom_range(3) * 85);
	endfunction

	task automatic push_load(input int x, input int y);
		pixel_item_t it;
		it.command = fsbm_pkg::CMD_LOAD;
		it.x = x[5:0]; it.y = y[5:0];
		it.cr = pick_colour(); it.cg = pick_colour(); it.cb = pick_colour();
		it.rr = pick_colour(); it.rg = pick_colour(); it.rb = pick_colour();
		loaded[y*FRAME_DIM + x] = 1;
		pending_items.push_back(it);
		items_queued++;
	endtask

	task automatic ensure_loaded(input int x, input int y);
		if (!loaded[y*FRAME_DIM + x]) push_load(x, y);
	endtask

	// load any pixel the search will read, then queue the estimate
	task automatic push_estimate(input int x, input int y);
		pixel_item_t it;
		int hb, x0, x1, y0, y1;
		if (search_window(x, y, hb, x0, x1, y0, y1) == fsbm_pkg::STATUS_MATCH) begin
			for (int dy = -hb; dy <= hb; dy++)
				for (int dx = -hb; dx <= hb; dx++)
					ensure_loaded(x + dx, y + dy);
			for (int yy = y0 - hb; yy <= y1 + hb; yy++)
				for (int xx = x0 - hb; xx <= x1 + hb; xx++)
					ensure_loaded(xx, yy);
		end
		it = '0;
		it.command = fsbm_pkg::CMD_ESTIMATE;
		it.x = x[5:0]; it.y = y[5:0];
		it.cr = 8'($urandom); it.cg = 8'($urandom); it.cb = 8'($urandom);
		it.rr = 8'($urandom); it.rg = 8'($urandom); it.rb = 8'($urandom);
		pending_items.push_back(it);
		items_queued++;
	endtask

	task automatic apb_write(input logic [1:0] index, input int value);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {index, 2'b00}; pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (index)
			fsbm_pkg::REG_WIDTH:  cfg_w  = value & 'h7f;
			fsbm_pkg::REG_HEIGHT: cfg_h  = value & 'h7f;
			fsbm_pkg::REG_HBLOCK: cfg_hb = value & 'h3;
			fsbm_pkg::REG_HWIN:   cfg_hw = value & 'hf;
		endcase
		@(negedge clk);
	endtask

	// drain every pending item and result, then let the block settle
	task automatic wait_idle();
		while (pending_items.size() != 0 || in_valid || expected_matches.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic set_config(input int w, input int h, input int hb, input int hw);
		wait_idle();
		apb_write(fsbm_pkg::REG_WIDTH, w);
		apb_write(fsbm_pkg::REG_HEIGHT, h);
		apb_write(fsbm_pkg::REG_HBLOCK, hb);
		apb_write(fsbm_pkg::REG_HWIN, hw);
	endtask

	function automatic int pick_dim();
		if ($urandom_range(99) < 85) return $urandom_range(32, 6);
		case ($urandom_range(4))
			0: return 0;
			1: return 1;
			2: return 64;
			3: return 100;
			default: return 127;
		endcase
	endfunction

	// queue about n items, counting the loads that estimates pull in
	task automatic random_items(input int n);
		int target, w, h, r;
		target = items_queued + n;
		w = clampi(cfg_w, 1, FRAME_DIM);
		h = clampi(cfg_h, 1, FRAME_DIM);
		while (items_queued < target) begin
			r = $urandom_range(99);
			if (r < 50)
				push_load($urandom_range(w - 1), $urandom_range(h - 1));
			else if (r < 55)
				push_load($urandom_range(63), $urandom_range(63));
			else if (r < 92)
				push_estimate($urandom_range(w - 1), $urandom_range(h - 1));
			else
				push_estimate($urandom_range(63), $urandom_range(63));
			// hand items over in small batches so the queue never runs far ahead
			while (pending_items.size() > 64) @(negedge clk);
		end
	endtask

	// driver: take accepted item into the predictor, then offer the next
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				if (drv.command == fsbm_pkg::CMD_LOAD) begin
					cur_frame[drv.y*FRAME_DIM + drv.x] = {drv.cb, drv.cg, drv.cr};
					ref_frame[drv.y*FRAME_DIM + drv.x] = {drv.rb, drv.rg, drv.rr};
				end else begin
					expected_matches.push_back(best_match(drv.x, drv.y));
				end
			end
			if (!in_valid || in_ready) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_idle) begin
					drv <= pending_items.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each result against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		match_t m;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_matches.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: status %0d sad %0d at (%0d,%0d)",
							status, best_sad, best_x, best_y);
				end else begin
					m = expected_matches.pop_front();
					if (status !== m.status || best_sad !== m.sad
							|| best_x !== m.bx || best_y !== m.by) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %0d/%0d/(%0d,%0d) got %0d/%0d/(%0d,%0d)",
								m.status, m.sad, m.bx, m.by,
								status, best_sad, best_x, best_y);
					end
				end
			end
			// hold off once for a long stretch so the block backs up
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (!hold_done && results_seen == 40) begin
				hold_done = 1;
				hold_left = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	// watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset settings, edges, corners and extreme colours
		pending_items.push_back('{fsbm_pkg::CMD_LOAD, 6'd0, 6'd0, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00, 8'h00});
		pending_items.push_back('{fsbm_pkg::CMD_LOAD, 6'd63, 6'd63, 8'hff, 8'hff, 8'hff,
			8'hff, 8'hff, 8'hff});
		loaded[0] = 1;
		loaded[FRAME_DIM*FRAME_DIM - 1] = 1;
		push_estimate(0, 0);
		push_estimate(63, 63);
		push_estimate(63, 10);

		// single candidate, zero half block: corners match
		set_config(64, 64, 0, 0);
		push_estimate(0, 0);
		push_estimate(63, 63);
		push_estimate(5, 5);

		// zero width acts as one, oversized height and window saturate
		set_config(0, 127, 3, 15);
		push_estimate(0, 0);
		push_estimate(0, 40);

		// window narrower than the block is empty
		set_config(64, 64, 2, 1);
		push_estimate(20, 20);
		push_estimate(1, 1);

		set_config(64, 64, 1, 1);
		push_estimate(1, 1);
		push_estimate(62, 62);

		// largest block and window
		set_config(64, 64, 3, 8);
		push_estimate(30, 30);
		push_estimate(3, 3);
		push_estimate(60, 60);

		// random phases with shifting idle patterns
		for (int p = 0; p < 9; p++) begin
			wait_idle();
			send_idle = (p < 3) ? 34 : (p < 6) ? 67 : 0;
			recv_idle = (p < 3) ? 67 : (p < 6) ? 34 : 0;
			set_config(pick_dim(), pick_dim(), $urandom_range(3),
				($urandom_range(99) < 85) ? $urandom_range(4) : $urandom_range(15));
			random_items(175);
		end

		wait_idle();
		repeat (50) @(negedge clk);
		if (mismatches == 0 && expected_matches.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### sim.f
rtl/fsbm_pkg.sv
rtl/fsbm_datapath.sv
rtl/fsbm_ctrl.sv
rtl/full_search_block_match_sad.sv
tb/tb_full_search_block_match_sad.sv
